>>> src/lpht_pkg.sv
// lpht_pkg: shared types, constants and the key hash for the hash table block.
// No dependencies.
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WORDS   = 6;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = SLOT_W + 1;
    localparam int HASH_ROT    = 17;
    localparam int DIV_BITS    = 4;
    localparam int DIV_CYCLES  = 64 / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(TABLE_DEPTH);
    localparam logic [7:0]        COUNT_MAX  = 8'd255;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_APPEND  = 3'd1;
    localparam logic [2:0] ST_FOUND   = 3'd2;
    localparam logic [2:0] ST_MISS    = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;

    typedef logic [KEY_WORDS-1:0][63:0] key_t;

    typedef struct packed {
        key_t        key;
        logic [63:0] value;
        logic [7:0]  count;
    } row_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_HOME,
        S_READ,
        S_CHECK,
        S_CLEAR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic probe_init;
        logic probe_adv;
        logic rd;
        logic commit;
        logic clr_init;
        logic clr_step;
        logic clr_fin;
        logic push_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       div_last;
        logic       hit_empty;
        logic       hit_match;
        logic       probe_last;
        logic       clr_last;
        logic       out_free;
    } stat_t;

    function automatic logic [63:0] hash_key(input key_t k);
        logic [63:0] h;
        h = '0;
        for (int w = 0; w < KEY_WORDS; w++) begin
            h = h ^ k[w];
            h = {h[63-HASH_ROT:0], h[63:64-HASH_ROT]};
        end
        return h;
    endfunction

endpackage

>>> src/lpht_ctrl.sv
// lpht_ctrl: operation sequencer for the hash table.
// Depends on lpht_pkg; drives lpht_dp through cmd_t, reads stat_t.
`timescale 1ns / 1ps

module lpht_ctrl import lpht_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  logic   in_op_clear,
    input  stat_t  stat,
    output cmd_t   cmd,
    output logic   in_stall
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_op_clear)
                    begin
                        cmd.clr_init = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    else
                        state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_HOME;
            end
            S_HOME:
            begin
                cmd.probe_init = 1'b1;
                state_next     = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.hit_empty || stat.hit_match || stat.probe_last)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    cmd.clr_fin = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.push_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

>>> src/lpht_dp.sv
// lpht_dp: hash table datapath: slot memories, modulo unit, probe index, result registers.
// Depends on lpht_pkg; controlled by lpht_ctrl.
`timescale 1ns / 1ps

module lpht_dp import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    input  logic [1:0]        in_op,
    input  key_t              in_key,
    input  logic [63:0]       in_value,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [2:0]        out_status,
    output logic [SLOT_W-1:0] out_slot,
    output logic [63:0]       out_value,
    output logic [7:0]        out_count,
    output logic [SIZE_W-1:0] out_entries
);

    logic [SIZE_W-1:0]    size_reg;
    logic [SIZE_W-1:0]    size_eff;
    logic [1:0]           op_reg;
    key_t                 key_reg;
    logic [63:0]          val_reg;
    logic [63:0]          divd_reg, divd_next;
    logic [SLOT_W-1:0]    rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic [SIZE_W-1:0]    pcnt_reg;
    logic [SLOT_W-1:0]    clr_reg;
    logic [SIZE_W-1:0]    occ_reg;

    row_t                 row_mem [TABLE_DEPTH];
    logic                 vld_mem [TABLE_DEPTH];
    row_t                 rrd_reg;
    logic                 vrd_reg;

    logic                 row_we, vld_we, vld_wd;
    logic [SLOT_W-1:0]    vld_wa;
    row_t                 row_wd;
    logic                 is_insert, match;
    logic [7:0]           cnt_sat;

    logic [2:0]           res_status_reg;
    logic [SLOT_W-1:0]    res_slot_reg;
    logic [63:0]          res_value_reg;
    logic [7:0]           res_count_reg;
    logic [SIZE_W-1:0]    res_entries_reg;

    logic                 out_valid_reg;
    logic [2:0]           out_status_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [63:0]          out_value_reg;
    logic [7:0]           out_count_reg;
    logic [SIZE_W-1:0]    out_entries_reg;

    always_comb
    begin
        if (size_reg == '0)
            size_eff = SIZE_W'(1);
        else if (size_reg > SIZE_RESET)
            size_eff = SIZE_RESET;
        else
            size_eff = size_reg;
    end

    // restoring remainder, DIV_BITS dividend bits per cycle
    always_comb
    begin
        logic [SIZE_W-1:0] t;
        logic [SLOT_W-1:0] r;
        logic [63:0]       d;
        r = rem_reg;
        d = divd_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            t = {r, d[63]};
            d = {d[62:0], 1'b0};
            if (t >= size_eff)
                t = t - size_eff;
            r = t[SLOT_W-1:0];
        end
        rem_next  = r;
        divd_next = d;
    end

    assign is_insert = (op_reg == OP_INSERT);
    assign match     = (rrd_reg.key == key_reg);
    assign cnt_sat   = (rrd_reg.count == COUNT_MAX) ? COUNT_MAX : rrd_reg.count + 8'd1;

    always_comb
    begin
        stat.op         = op_reg;
        stat.div_last   = (dcnt_reg == DIV_CNT_W'(DIV_CYCLES - 1));
        stat.hit_empty  = !vrd_reg;
        stat.hit_match  = vrd_reg && match;
        stat.probe_last = (pcnt_reg == size_eff - SIZE_W'(1));
        stat.clr_last   = (clr_reg == SLOT_W'(TABLE_DEPTH - 1));
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        row_we = 1'b0;
        row_wd = rrd_reg;
        vld_we = cmd.clr_step;
        vld_wd = 1'b0;
        vld_wa = cmd.clr_step ? clr_reg : idx_reg;
        if (cmd.commit && is_insert)
        begin
            if (!vrd_reg)
            begin
                row_we       = 1'b1;
                row_wd.key   = key_reg;
                row_wd.value = val_reg;
                row_wd.count = 8'd1;
                vld_we       = 1'b1;
                vld_wd       = 1'b1;
            end
            else if (match)
            begin
                row_we       = 1'b1;
                row_wd.count = cnt_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[idx_reg] <= row_wd;
        if (cmd.rd)
            rrd_reg <= row_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (vld_we)
            vld_mem[vld_wa] <= vld_wd;
        if (cmd.rd)
            vrd_reg <= vld_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= in_key;
            val_reg  <= in_value;
            divd_reg <= hash_key(in_key);
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            divd_reg <= divd_next;
            rem_reg  <= rem_next;
        end
        if (cmd.probe_init)
        begin
            idx_reg  <= rem_reg;
            pcnt_reg <= '0;
        end
        else if (cmd.probe_adv)
        begin
            pcnt_reg <= pcnt_reg + SIZE_W'(1);
            if ({1'b0, idx_reg} + SIZE_W'(1) == size_eff)
                idx_reg <= '0;
            else
                idx_reg <= idx_reg + SLOT_W'(1);
        end
        if (cmd.commit)
        begin
            res_entries_reg <= occ_reg;
            res_slot_reg    <= '0;
            res_value_reg   <= '0;
            res_count_reg   <= '0;
            if (!vrd_reg)
            begin
                if (is_insert)
                begin
                    res_status_reg  <= ST_NEW;
                    res_slot_reg    <= idx_reg;
                    res_value_reg   <= val_reg;
                    res_count_reg   <= 8'd1;
                    res_entries_reg <= occ_reg + SIZE_W'(1);
                end
                else
                    res_status_reg <= ST_MISS;
            end
            else if (match)
            begin
                res_status_reg <= is_insert ? ST_APPEND : ST_FOUND;
                res_slot_reg   <= idx_reg;
                res_value_reg  <= rrd_reg.value;
                res_count_reg  <= is_insert ? cnt_sat : rrd_reg.count;
            end
            else
                res_status_reg <= is_insert ? ST_FULL : ST_MISS;
        end
        else if (cmd.clr_fin)
        begin
            res_status_reg  <= ST_CLEARED;
            res_slot_reg    <= '0;
            res_value_reg   <= '0;
            res_count_reg   <= '0;
            res_entries_reg <= '0;
        end
        if (cmd.push_out)
        begin
            out_status_reg  <= res_status_reg;
            out_slot_reg    <= res_slot_reg;
            out_value_reg   <= res_value_reg;
            out_count_reg   <= res_count_reg;
            out_entries_reg <= res_entries_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_RESET;
            op_reg        <= OP_LOOKUP;
            dcnt_reg      <= '0;
            clr_reg       <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                size_reg <= cfg_wr_data;
            if (cmd.load)
            begin
                op_reg   <= in_op;
                dcnt_reg <= '0;
            end
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
            if (cmd.clr_init)
                clr_reg <= '0;
            else if (cmd.clr_step)
                clr_reg <= clr_reg + SLOT_W'(1);
            if (cmd.clr_fin)
                occ_reg <= '0;
            else if (cmd.commit && is_insert && !vrd_reg)
                occ_reg <= occ_reg + SIZE_W'(1);
            if (cmd.push_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_slot    = out_slot_reg;
    assign out_value   = out_value_reg;
    assign out_count   = out_count_reg;
    assign out_entries = out_entries_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= SIZE_RESET)
        else $error("entry count above table depth");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> ({1'b0, idx_reg} < size_eff))
        else $error("probe index outside active table");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> ({1'b0, rem_reg} < size_eff))
        else $error("partial remainder not reduced");

    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_out |=> out_valid_reg)
        else $error("result register not loaded");

    a_full_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && is_insert && !vrd_reg) |-> (occ_reg < SIZE_RESET))
        else $error("new entry with every slot occupied");

endmodule

>>> src/linear_probe_hash_table.sv
// Lookup/insert: load, hash modulo, home slot, then a read and a check per probed slot, then the result;
// one transaction at a time (in_stall stays high until the result is pushed), paced by the 4-bit-per-cycle modulo unit
// and the registered slot memory read in the probe loop.
// Clear walks one slot a cycle through the valid-bit memory.
// After reset the same pass over every slot runs with in_stall high; config writes still land.
`timescale 1ns / 1ps

module linear_probe_hash_table import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [63:0]       key_word_0,
    input  logic [63:0]       key_word_1,
    input  logic [63:0]       key_word_2,
    input  logic [63:0]       key_word_3,
    input  logic [63:0]       key_word_4,
    input  logic [63:0]       key_word_5,
    input  logic [63:0]       new_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic [SLOT_W-1:0] slot,
    output logic [63:0]       stored_value,
    output logic [7:0]        value_count,
    output logic [SIZE_W-1:0] entry_count
);

    cmd_t cmd;
    stat_t stat;
    key_t key;

    assign key = {key_word_5, key_word_4, key_word_3, key_word_2, key_word_1, key_word_0};

    lpht_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_op_clear (opcode == OP_CLEAR),
        .stat        (stat),
        .cmd         (cmd),
        .in_stall    (in_stall)
    );

    lpht_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_op       (opcode),
        .in_key      (key),
        .in_value    (new_value),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_status  (status),
        .out_slot    (slot),
        .out_value   (stored_value),
        .out_count   (value_count),
        .out_entries (entry_count)
    );

endmodule

>>> tb/lpht_checker.sv
// lpht_checker: watches the config port and both channels of the hash table,
// keeps its own copy of the table and compares every result. Uses lpht_pkg.
`timescale 1ns / 1ps

module lpht_checker import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [63:0]       key_word_0,
    input  logic [63:0]       key_word_1,
    input  logic [63:0]       key_word_2,
    input  logic [63:0]       key_word_3,
    input  logic [63:0]       key_word_4,
    input  logic [63:0]       key_word_5,
    input  logic [63:0]       new_value,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [2:0]        status,
    input  logic [SLOT_W-1:0] slot,
    input  logic [63:0]       stored_value,
    input  logic [7:0]        value_count,
    input  logic [SIZE_W-1:0] entry_count,
    output int                pending,
    output int                fail_count
);

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [63:0]       value;
        logic [7:0]        count;
        logic [SIZE_W-1:0] entries;
    } answer_t;

    answer_t           answers[$];
    logic              used[TABLE_DEPTH];
    key_t              keys[TABLE_DEPTH];
    logic [63:0]       values[TABLE_DEPTH];
    logic [7:0]        counts[TABLE_DEPTH];
    logic [SIZE_W-1:0] occupied;
    logic [SIZE_W-1:0] size_reg;

    assign pending = answers.size();

    function automatic int span();
        int s;
        s = size_reg;
        if (s == 0) s = 1;
        if (s > TABLE_DEPTH) s = TABLE_DEPTH;
        return s;
    endfunction

    // 0 no room, 1 key found, 2 empty slot found
    function automatic int search(input key_t k, output int where);
        logic [63:0] h;
        int          n;
        int          idx;
        n = span();
        h = '0;
        for (int w = 0; w < KEY_WORDS; w++) begin
            h = h ^ k[w];
            h = {h[46:0], h[63:47]};
        end
        idx = int'(h % 64'(n));
        where = 0;
        for (int i = 0; i < n; i++) begin
            if (!used[idx]) begin
                where = idx;
                return 2;
            end
            if (keys[idx] == k) begin
                where = idx;
                return 1;
            end
            idx = (idx + 1 >= n) ? 0 : idx + 1;
        end
        return 0;
    endfunction

    task automatic apply_transaction(input logic [1:0] op, input key_t k, input logic [63:0] v);
        answer_t a;
        int      hit;
        int      where;
        a = '0;
        if (op == OP_CLEAR) begin
            foreach (used[i]) used[i] = 1'b0;
            occupied = '0;
            a.status = ST_CLEARED;
        end else if (op == OP_INSERT) begin
            hit = search(k, where);
            if (hit == 1) begin
                if (counts[where] != COUNT_MAX) counts[where]++;
                a.status = ST_APPEND;
                a.slot = SLOT_W'(where);
                a.value = values[where];
                a.count = counts[where];
            end else if (hit == 2) begin
                used[where] = 1'b1;
                keys[where] = k;
                values[where] = v;
                counts[where] = 8'd1;
                occupied++;
                a.status = ST_NEW;
                a.slot = SLOT_W'(where);
                a.value = v;
                a.count = 8'd1;
            end else begin
                a.status = ST_FULL;
            end
        end else begin
            hit = search(k, where);
            if (hit == 1) begin
                a.status = ST_FOUND;
                a.slot = SLOT_W'(where);
                a.value = values[where];
                a.count = counts[where];
            end else begin
                a.status = ST_MISS;
            end
        end
        if (op != OP_CLEAR) a.entries = occupied;
        answers.push_back(a);
    endtask

    always @(posedge clk or negedge rst_n) begin
        answer_t a;
        if (!rst_n) begin
            answers.delete();
            foreach (used[i]) used[i] = 1'b0;
            occupied = '0;
            size_reg = SIZE_RESET;
            fail_count = 0;
        end else begin
            if (cfg_wr_en) size_reg = cfg_wr_data;
            if (in_valid && !in_stall)
                apply_transaction(opcode, {key_word_5, key_word_4, key_word_3,
                                           key_word_2, key_word_1, key_word_0}, new_value);
            if (out_valid && !out_stall) begin
                if (answers.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end else begin
                    a = answers.pop_front();
                    if (status !== a.status) begin
                        $error("status: expected %0d, got %0d", a.status, status);
                        fail_count++;
                    end
                    if (slot !== a.slot) begin
                        $error("slot: expected %0d, got %0d", a.slot, slot);
                        fail_count++;
                    end
                    if (stored_value !== a.value) begin
                        $error("stored_value: expected %h, got %h", a.value, stored_value);
                        fail_count++;
                    end
                    if (value_count !== a.count) begin
                        $error("value_count: expected %0d, got %0d", a.count, value_count);
                        fail_count++;
                    end
                    if (entry_count !== a.entries) begin
                        $error("entry_count: expected %0d, got %0d", a.entries, entry_count);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/linear_probe_hash_table_test.sv
// linear_probe_hash_table_test: clock, reset, stimulus and verdict for the hash table.
// Depends on lpht_pkg, linear_probe_hash_table and lpht_checker.
`timescale 1ns / 1ps

module linear_probe_hash_table_test;
    import lpht_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0] cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        opcode = OP_LOOKUP;
    logic [63:0]       key_word_0 = '0;
    logic [63:0]       key_word_1 = '0;
    logic [63:0]       key_word_2 = '0;
    logic [63:0]       key_word_3 = '0;
    logic [63:0]       key_word_4 = '0;
    logic [63:0]       key_word_5 = '0;
    logic [63:0]       new_value = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       stored_value;
    logic [7:0]        value_count;
    logic [SIZE_W-1:0] entry_count;
    int                pending;
    int                fail_count;
    int                gap_left = 0;
    int                burst_left = 0;
    key_t              key_pool[32];

    always #5 clk = ~clk;

    linear_probe_hash_table dut (.*);

    lpht_checker check (.*);

    // receiver: random stall patterns drawn in turn, interrupted by long hold-offs
    initial begin
        int cyc;
        int mode;
        int hold;
        cyc = 0;
        mode = 0;
        hold = 0;
        forever begin
            @(negedge clk);
            cyc++;
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            if (cyc % 5000 == 0) hold = 400;
            if (hold > 0) begin
                hold--;
                out_stall = 1'b1;
            end else begin
                case (mode)
                    0: out_stall = 1'b0;
                    1: out_stall = ($urandom_range(0, 3) == 0);
                    2: out_stall = ($urandom_range(0, 3) != 0);
                    default: out_stall = cyc[2];
                endcase
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic key_t rand_key();
        key_t k;
        for (int w = 0; w < KEY_WORDS; w++) k[w] = rand64();
        return k;
    endfunction

    task automatic send(input logic [1:0] op, input key_t k, input logic [63:0] v);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
        if (gap_left > 0) begin
            in_valid = 1'b0;
            repeat (gap_left) @(negedge clk);
            gap_left = 0;
        end
        burst_left--;
        opcode = op;
        {key_word_5, key_word_4, key_word_3, key_word_2, key_word_1, key_word_0} = k;
        new_value = v;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic set_size(input int n);
        wait_idle();
        cfg_wr_en = 1'b1;
        cfg_wr_data = SIZE_W'(n);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic run_phase(input int size, input int items, input int pool_n,
                             input int insert_pct);
        int   r;
        key_t k;
        set_size(size);
        for (int i = 0; i < pool_n; i++) key_pool[i] = rand_key();
        for (int i = 0; i < items; i++) begin
            k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_n - 1)]
                                             : rand_key();
            r = $urandom_range(0, 99);
            if (r < 2)
                send(OP_CLEAR, k, rand64());
            else if (r < insert_pct)
                send(OP_INSERT, k, rand64());
            else
                send((r % 5 == 0) ? 2'd3 : OP_LOOKUP, k, rand64());
        end
    endtask

    initial begin
        key_t ka;
        key_t kb;
        ka = rand_key();
        kb = rand_key();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every opcode, miss, append, clear, full, size limits
        set_size(1024);
        send(OP_LOOKUP, '0, '0);
        send(OP_INSERT, '0, '0);
        send(OP_INSERT, '1, '1);
        send(OP_INSERT, '1, '0);
        send(OP_LOOKUP, '1, '0);
        send(2'd3, '0, '1);
        send(OP_LOOKUP, ka, '0);
        send(OP_CLEAR, '1, '1);
        send(OP_LOOKUP, '1, '0);
        set_size(1);
        send(OP_INSERT, ka, rand64());
        send(OP_INSERT, kb, rand64());
        send(OP_INSERT, ka, rand64());
        send(OP_LOOKUP, kb, '0);
        set_size(0);
        send(OP_INSERT, kb, rand64());
        send(OP_LOOKUP, ka, '0);
        send(OP_CLEAR, '0, '0);
        set_size(2047);
        send(OP_INSERT, ka, '1);
        send(OP_LOOKUP, ka, '0);
        send(OP_CLEAR, '0, '0);

        // random phases; size 3 shrinks the table while entries remain
        run_phase(1, 300, 1, 95);
        run_phase(2047, 60, 16, 60);
        run_phase(5, 60, 8, 60);
        run_phase(3, 40, 8, 50);
        run_phase(16, 60, 24, 60);
        run_phase(0, 30, 4, 50);
        run_phase(1024, 50, 16, 55);

        wait_idle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
src/lpht_pkg.sv
src/lpht_ctrl.sv
src/lpht_dp.sv
src/linear_probe_hash_table.sv
tb/lpht_checker.sv
tb/linear_probe_hash_table_test.sv
